@@ design/blrs_pkg.sv @@
// shared types and constants of the line rasterizer
package blrs_pkg;

  localparam int unsigned WIDTH_BITS  = 15;
  localparam int unsigned STRIDE_BITS = 18;
  localparam int unsigned BPP_BITS    = 4;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned COLOR_BITS  = 32;
  localparam int unsigned REG_IDX_BITS = 3;

  localparam logic [WIDTH_BITS-1:0]  IMAGE_WIDTH_RST  = 15'd1024;
  localparam logic [WIDTH_BITS-1:0]  IMAGE_HEIGHT_RST = 15'd768;
  localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RST   = 18'd4096;
  localparam logic [BPP_BITS-1:0]    BPP_RST          = 4'd4;
  localparam logic [ADDR_BITS-1:0]   FRAME_BASE_RST   = 32'd0;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_ROW_STRIDE      = 3'd2,
    REG_BYTES_PER_PIXEL = 3'd3,
    REG_FRAME_BASE      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic allowed;
    logic done;
  } pix_flags_t;

endpackage

@@ design/blrs_step.sv @@
// line state and one bresenham step per transfer, with the pixel register
module blrs_step
  import blrs_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic [COLOR_BITS-1:0]        in_line_color,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output logic signed [COORD_BITS-1:0] pix_x,
  output logic signed [COORD_BITS-1:0] pix_y,
  output logic [COLOR_BITS-1:0]        pix_color,
  output pix_flags_t                   pix_flags
);

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned D = COORD_BITS + 1;
  localparam int unsigned E = COORD_BITS + 3;
  localparam int unsigned T = COORD_BITS + 4;

  logic signed [C-1:0]   cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic signed [C-1:0]   cur_x_nxt, cur_y_nxt, tgt_x_nxt, tgt_y_nxt;
  logic signed [D-1:0]   dx_r, ndy_r, dx_nxt, ndy_nxt;
  logic signed [E-1:0]   err_r, err_nxt;
  logic                  sxn_r, syn_r, sxn_nxt, syn_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;
  logic                  active_r, active_nxt;

  logic signed [C-1:0]   pix_x_r, pix_y_r, pix_x_nxt, pix_y_nxt;
  pix_flags_t            pix_flags_r, pix_flags_nxt;
  logic                  pix_valid_r;

  logic                  accept;

  logic signed [D-1:0]   diff_x, diff_y, abs_x, abs_y;
  logic signed [T-1:0]   twice;
  logic                  move_x, move_y, guard_x, guard_y;
  logic signed [C-1:0]   step_x, step_y, x_after, y_after;
  logic signed [E-1:0]   err_after;

  assign in_ready = !pix_valid_r || pix_ready;
  assign accept   = in_valid && in_ready;

  // start setup
  assign diff_x = {in_end_x[C-1], in_end_x} - {in_start_x[C-1], in_start_x};
  assign diff_y = {in_end_y[C-1], in_end_y} - {in_start_y[C-1], in_start_y};
  assign abs_x  = diff_x[D-1] ? -diff_x : diff_x;
  assign abs_y  = diff_y[D-1] ? -diff_y : diff_y;

  // one step of the error walk
  assign twice   = {err_r, 1'b0};
  assign move_x  = twice >= T'(ndy_r);
  assign move_y  = twice <= T'(dx_r);
  assign guard_x = move_x && (cur_x_r == tgt_x_r);
  assign step_x  = sxn_r ? cur_x_r - C'(1) : cur_x_r + C'(1);
  assign step_y  = syn_r ? cur_y_r - C'(1) : cur_y_r + C'(1);
  assign x_after = move_x ? step_x : cur_x_r;
  assign guard_y = move_y && (cur_y_r == tgt_y_r);
  assign y_after = (move_y && !guard_y) ? step_y : cur_y_r;
  assign err_after = err_r + (move_x ? E'(ndy_r) : E'(0))
                   + ((move_y && !guard_y) ? E'(dx_r) : E'(0));

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    tgt_x_nxt  = tgt_x_r;
    tgt_y_nxt  = tgt_y_r;
    dx_nxt     = dx_r;
    ndy_nxt    = ndy_r;
    err_nxt    = err_r;
    sxn_nxt    = sxn_r;
    syn_nxt    = syn_r;
    color_nxt  = color_r;
    active_nxt = active_r;
    pix_x_nxt  = cur_x_r;
    pix_y_nxt  = cur_y_r;
    pix_flags_nxt = '{allowed: 1'b0, done: 1'b1};
    priority if (in_opcode == OP_START) begin
      cur_x_nxt  = in_start_x;
      cur_y_nxt  = in_start_y;
      tgt_x_nxt  = in_end_x;
      tgt_y_nxt  = in_end_y;
      dx_nxt     = abs_x;
      ndy_nxt    = -abs_y;
      err_nxt    = E'(abs_x) - E'(abs_y);
      sxn_nxt    = !(in_start_x < in_end_x);
      syn_nxt    = !(in_start_y < in_end_y);
      color_nxt  = in_line_color;
      active_nxt = !((in_start_x == in_end_x) && (in_start_y == in_end_y));
      pix_x_nxt  = in_start_x;
      pix_y_nxt  = in_start_y;
      pix_flags_nxt = '{allowed: 1'b1, done: !active_nxt};
    end else if (!active_r) begin
      pix_flags_nxt = '{allowed: 1'b0, done: 1'b1};
    end else if (guard_x) begin
      active_nxt = 1'b0;
    end else if (guard_y) begin
      cur_x_nxt  = x_after;
      err_nxt    = err_after;
      active_nxt = 1'b0;
      pix_x_nxt  = x_after;
    end else begin
      cur_x_nxt  = x_after;
      cur_y_nxt  = y_after;
      err_nxt    = err_after;
      active_nxt = !((x_after == tgt_x_r) && (y_after == tgt_y_r));
      pix_x_nxt  = x_after;
      pix_y_nxt  = y_after;
      pix_flags_nxt = '{allowed: 1'b1, done: !active_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      dx_r        <= '0;
      ndy_r       <= '0;
      err_r       <= '0;
      sxn_r       <= 1'b0;
      syn_r       <= 1'b0;
      color_r     <= '0;
      active_r    <= 1'b0;
      pix_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cur_x_r  <= cur_x_nxt;
        cur_y_r  <= cur_y_nxt;
        tgt_x_r  <= tgt_x_nxt;
        tgt_y_r  <= tgt_y_nxt;
        dx_r     <= dx_nxt;
        ndy_r    <= ndy_nxt;
        err_r    <= err_nxt;
        sxn_r    <= sxn_nxt;
        syn_r    <= syn_nxt;
        color_r  <= color_nxt;
        active_r <= active_nxt;
      end
      if (in_ready) begin
        pix_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_x_r     <= pix_x_nxt;
      pix_y_r     <= pix_y_nxt;
      pix_flags_r <= pix_flags_nxt;
    end
  end

  assign pix_valid = pix_valid_r;
  assign pix_x     = pix_x_r;
  assign pix_y     = pix_y_r;
  assign pix_color = color_r;
  assign pix_flags = pix_flags_r;

  a_active_not_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !((cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r)))
    else $error("active line sits at its endpoint");

  a_idle_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_ADVANCE) && !active_r)
      |=> pix_valid_r && pix_flags_r.done && !pix_flags_r.allowed && !active_r)
    else $error("advance while idle changed the line");

  a_done_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pix_flags_nxt.done) |=> !active_r)
    else $error("line still active after its last pixel");

endmodule

@@ design/blrs_addr.sv @@
// clipping and framebuffer address, two register stages
module blrs_addr
  import blrs_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pix_valid,
  output logic                         pix_ready,
  input  logic signed [COORD_BITS-1:0] pix_x,
  input  logic signed [COORD_BITS-1:0] pix_y,
  input  logic [COLOR_BITS-1:0]        pix_color,
  input  pix_flags_t                   pix_flags,
  input  logic [WIDTH_BITS-1:0]        image_width,
  input  logic [WIDTH_BITS-1:0]        image_height,
  input  logic [STRIDE_BITS-1:0]       row_stride,
  input  logic [BPP_BITS-1:0]          bytes_per_pixel,
  input  logic [ADDR_BITS-1:0]         frame_base,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_write_enable,
  output logic [ADDR_BITS-1:0]         out_pixel_address,
  output logic [COLOR_BITS-1:0]        out_pixel_value,
  output logic                         out_line_done
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned CW = (COORD_BITS > WIDTH_BITS) ? COORD_BITS : WIDTH_BITS;
  localparam int unsigned PY = WIDTH_BITS + STRIDE_BITS;
  localparam int unsigned PX = WIDTH_BITS + BPP_BITS;

  logic                  mul_valid_r, res_valid_r;
  logic                  mul_ready, accept_mul, accept_res;
  logic                  in_image;
  logic [WIDTH_BITS-1:0] xl, yl;
  logic [PY-1:0]         py_full;
  logic [PX-1:0]         px_full;

  logic signed [C-1:0]   mx_r, my_r;
  logic                  inside_r, mdone_r;
  logic [ADDR_BITS-1:0]  py_r;
  logic [PX-1:0]         px_r;
  logic [COLOR_BITS-1:0] mcolor_r;

  logic signed [C-1:0]   rx_r, ry_r;
  logic                  we_r, rdone_r;
  logic [ADDR_BITS-1:0]  addr_r, addr_nxt;
  logic [COLOR_BITS-1:0] rcolor_r;

  assign mul_ready  = !res_valid_r || out_ready;
  assign pix_ready  = !mul_valid_r || mul_ready;
  assign accept_mul = pix_valid && pix_ready;
  assign accept_res = mul_valid_r && mul_ready;

  assign in_image = pix_flags.allowed && !pix_x[C-1] && !pix_y[C-1]
                 && (CW'($unsigned(pix_x)) < CW'(image_width))
                 && (CW'($unsigned(pix_y)) < CW'(image_height));
  assign xl = WIDTH_BITS'($unsigned(pix_x));
  assign yl = WIDTH_BITS'($unsigned(pix_y));
  assign py_full = PY'(yl) * PY'(row_stride);
  assign px_full = PX'(xl) * PX'(bytes_per_pixel);

  assign addr_nxt = inside_r ? frame_base + py_r + ADDR_BITS'(px_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (pix_ready) begin
        mul_valid_r <= pix_valid;
      end
      if (mul_ready) begin
        res_valid_r <= mul_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_mul) begin
      mx_r     <= pix_x;
      my_r     <= pix_y;
      inside_r <= in_image;
      mdone_r  <= pix_flags.done;
      py_r     <= py_full[ADDR_BITS-1:0];
      px_r     <= px_full;
      mcolor_r <= pix_color;
    end
    if (accept_res) begin
      rx_r     <= mx_r;
      ry_r     <= my_r;
      we_r     <= inside_r;
      rdone_r  <= mdone_r;
      addr_r   <= addr_nxt;
      rcolor_r <= mcolor_r;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_pixel_x       = rx_r;
  assign out_pixel_y       = ry_r;
  assign out_write_enable  = we_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_value   = rcolor_r;
  assign out_line_done     = rdone_r;

  a_addr_zero_when_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_pixel_address == '0))
    else $error("clipped pixel carries an address");

  a_write_has_nonneg_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_write_enable) |-> (!out_pixel_x[C-1] && !out_pixel_y[C-1]))
    else $error("write enable on a negative coordinate");

endmodule

@@ design/bresenham_line_rasterizer_top.sv @@
// top level of the line rasterizer: register port, step unit and address unit
// Takes one item per clock while the output is not stalled, start (opcode 0) or
// advance (opcode 1), and gives one pixel per item through the pixel, multiply and
// result registers; the whole bresenham step, including its error update, is
// combinational in the step unit, and the address product y*row_stride is
// registered before the final add with frame_base. Configuration registers are
// written through the APB port at byte addresses 0, 4, 8, 12 and 16 and must
// only change while no line pixels are in flight.
module bresenham_line_rasterizer_top
  import blrs_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_opcode,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic [COLOR_BITS-1:0]        in_line_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic                         out_write_enable,
  output logic [ADDR_BITS-1:0]         out_pixel_address,
  output logic [COLOR_BITS-1:0]        out_pixel_value,
  output logic                         out_line_done
);

  logic [WIDTH_BITS-1:0]   image_width_r, image_height_r;
  logic [STRIDE_BITS-1:0]  row_stride_r;
  logic [BPP_BITS-1:0]     bpp_r;
  logic [ADDR_BITS-1:0]    frame_base_r;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    cfg_wr;

  logic                    pix_valid, pix_ready;
  logic signed [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOR_BITS-1:0]   pix_color;
  pix_flags_t              pix_flags;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      row_stride_r   <= ROW_STRIDE_RST;
      bpp_r          <= BPP_RST;
      frame_base_r   <= FRAME_BASE_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:     image_width_r  <= pwdata[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT:    image_height_r <= pwdata[WIDTH_BITS-1:0];
        REG_ROW_STRIDE:      row_stride_r   <= pwdata[STRIDE_BITS-1:0];
        REG_BYTES_PER_PIXEL: bpp_r          <= pwdata[BPP_BITS-1:0];
        REG_FRAME_BASE:      frame_base_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:     prdata = 32'(image_width_r);
      REG_IMAGE_HEIGHT:    prdata = 32'(image_height_r);
      REG_ROW_STRIDE:      prdata = 32'(row_stride_r);
      REG_BYTES_PER_PIXEL: prdata = 32'(bpp_r);
      REG_FRAME_BASE:      prdata = frame_base_r;
      default:             prdata = '0;
    endcase
  end

  blrs_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .in_line_color (in_line_color),
    .pix_valid     (pix_valid),
    .pix_ready     (pix_ready),
    .pix_x         (pix_x),
    .pix_y         (pix_y),
    .pix_color     (pix_color),
    .pix_flags     (pix_flags)
  );

  blrs_addr #(
    .COORD_BITS(COORD_BITS)
  ) u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .pix_valid         (pix_valid),
    .pix_ready         (pix_ready),
    .pix_x             (pix_x),
    .pix_y             (pix_y),
    .pix_color         (pix_color),
    .pix_flags         (pix_flags),
    .image_width       (image_width_r),
    .image_height      (image_height_r),
    .row_stride        (row_stride_r),
    .bytes_per_pixel   (bpp_r),
    .frame_base        (frame_base_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_write_enable  (out_write_enable),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_line_done     (out_line_done)
  );

endmodule
